@@ hw/rtl/dms_pkg.sv @@
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants of the dominant model selector.
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int MAX_STACK_DEF = 16;

    localparam int VAL_W   = 32;
    localparam int CLASS_W = 8;
    localparam int MC_W    = 2;
    localparam int REG_W   = 3;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_NA_VALUE       = 3'd0;
    localparam logic [REG_W-1:0] REG_LOWER_FRACTION = 3'd1;
    localparam logic [REG_W-1:0] REG_UPPER_FRACTION = 3'd2;
    localparam logic [REG_W-1:0] REG_RMSE_LIMIT     = 3'd3;
    localparam logic [REG_W-1:0] REG_RMSE_MARGIN    = 3'd4;

    localparam logic signed [VAL_W-1:0] NA_VALUE_RST       = 32'sd0;
    localparam logic signed [VAL_W-1:0] LOWER_FRACTION_RST = 32'sd0;
    localparam logic signed [VAL_W-1:0] UPPER_FRACTION_RST = 32'sd65536;
    localparam logic signed [VAL_W-1:0] RMSE_LIMIT_RST     = 32'sd65536;
    localparam logic signed [VAL_W-1:0] RMSE_MARGIN_RST    = 32'sd0;

    // model kinds
    localparam logic [MC_W-1:0] MC_TWO   = 2'd2;
    localparam logic [MC_W-1:0] MC_THREE = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] na_value;
        logic signed [VAL_W-1:0] lower_fraction;
        logic signed [VAL_W-1:0] upper_fraction;
        logic signed [VAL_W-1:0] rmse_limit;
        logic signed [VAL_W-1:0] rmse_margin;
    } dms_cfg_t;

    typedef struct packed {
        logic                    last_entry;
        logic [CLASS_W-1:0]      class_b;
        logic [CLASS_W-1:0]      class_a;
        logic signed [VAL_W-1:0] fit_error;
        logic signed [VAL_W-1:0] frac_b;
        logic signed [VAL_W-1:0] frac_a;
        logic [MC_W-1:0]         model_count;
    } dms_entry_t;

    typedef struct packed {
        logic                    status;
        logic [CLASS_W-1:0]      dominant_class;
        logic signed [VAL_W-1:0] dominant_value;
    } dms_result_t;

endpackage

@@ hw/rtl/dms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dms_cfg_regs
// Configuration register file: thresholds and the no-data marker.
// ----------------------------------------------------------------------------
module dms_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dms_pkg::REG_W-1:0]       wr_index,
    input  logic [dms_pkg::VAL_W-1:0]       wr_data,
    output dms_pkg::dms_cfg_t               cfg
);

    dms_pkg::dms_cfg_t cfg_reg;
    dms_pkg::dms_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                dms_pkg::REG_NA_VALUE:       cfg_next.na_value       = $signed(wr_data);
                dms_pkg::REG_LOWER_FRACTION: cfg_next.lower_fraction = $signed(wr_data);
                dms_pkg::REG_UPPER_FRACTION: cfg_next.upper_fraction = $signed(wr_data);
                dms_pkg::REG_RMSE_LIMIT:     cfg_next.rmse_limit     = $signed(wr_data);
                dms_pkg::REG_RMSE_MARGIN:    cfg_next.rmse_margin    = $signed(wr_data);
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.na_value       <= dms_pkg::NA_VALUE_RST;
            cfg_reg.lower_fraction <= dms_pkg::LOWER_FRACTION_RST;
            cfg_reg.upper_fraction <= dms_pkg::UPPER_FRACTION_RST;
            cfg_reg.rmse_limit     <= dms_pkg::RMSE_LIMIT_RST;
            cfg_reg.rmse_margin    <= dms_pkg::RMSE_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/dms_stack_core.sv @@
// ----------------------------------------------------------------------------
// dms_stack_core
// Carried winner of one pixel stack, validity test, counters and the
// result register.
// ----------------------------------------------------------------------------
module dms_stack_core #(
    parameter int MAX_STACK = dms_pkg::MAX_STACK_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dms_pkg::dms_cfg_t     cfg,
    input  logic                  in_valid,
    input  dms_pkg::dms_entry_t   in_entry,
    output logic                  in_take,
    output logic                  res_valid,
    input  logic                  res_ready,
    output dms_pkg::dms_result_t  res
);

    localparam int CNT_W = $clog2(MAX_STACK + 1);
    localparam int DIF_W = dms_pkg::VAL_W + 1;

    // carried entry, no reset needed: ignored while the stack is empty
    logic [dms_pkg::CLASS_W-1:0]      held_class_reg,    held_class_next;
    logic signed [dms_pkg::VAL_W-1:0] held_fraction_reg, held_fraction_next;
    logic signed [dms_pkg::VAL_W-1:0] held_rmse_reg,     held_rmse_next;
    logic                             held_is_three_reg, held_is_three_next;

    logic [CNT_W-1:0] entry_cnt_reg, entry_cnt_next;
    logic [CNT_W-1:0] inv_cnt_reg,   inv_cnt_next;
    logic             bad_flag_reg,  bad_flag_next;

    logic                 res_valid_reg, res_valid_next;
    dms_pkg::dms_result_t res_reg,       res_next;

    logic                             three;
    logic                             bad_model;
    logic signed [dms_pkg::VAL_W-1:0] frac;
    logic [dms_pkg::CLASS_W-1:0]      cls;
    logic                             first;
    logic                             held_inv;
    logic                             held_gt;
    logic signed [DIF_W-1:0]          diff_he;
    logic signed [DIF_W-1:0]          diff_eh;
    logic signed [DIF_W-1:0]          margin;
    logic                             keep;
    logic [CNT_W-1:0]                 inv_sum;
    logic [CNT_W-1:0]                 cnt_sum;
    logic                             bad_sum;
    logic                             emit;

    assign in_take = in_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        three     = (in_entry.model_count == dms_pkg::MC_THREE);
        bad_model = (in_entry.model_count != dms_pkg::MC_TWO) && !three;

        if (three && ($signed(in_entry.frac_b) > $signed(in_entry.frac_a)))
        begin
            frac = in_entry.frac_b;
            cls  = in_entry.class_b;
        end
        else
        begin
            frac = in_entry.frac_a;
            cls  = in_entry.class_a;
        end

        first    = (entry_cnt_reg == '0);
        held_inv = (held_fraction_reg == $signed(cfg.na_value))
                || (held_rmse_reg == $signed(cfg.na_value))
                || (held_fraction_reg < $signed(cfg.lower_fraction))
                || (held_fraction_reg > $signed(cfg.upper_fraction))
                || (held_rmse_reg > $signed(cfg.rmse_limit));
        held_gt  = held_fraction_reg > frac;

        // exact rmse differences, one bit wider than the operands
        diff_he = DIF_W'(held_rmse_reg) - DIF_W'($signed(in_entry.fit_error));
        diff_eh = DIF_W'($signed(in_entry.fit_error)) - DIF_W'(held_rmse_reg);
        margin  = DIF_W'($signed(cfg.rmse_margin));

        if (first || held_inv)
            keep = 1'b0;
        else if (held_is_three_reg == three)
            keep = held_gt;
        else if (!held_is_three_reg)
            keep = (diff_he <= margin) || held_gt;
        else
            keep = (diff_eh > margin) && held_gt;

        inv_sum = inv_cnt_reg + CNT_W'(!first && held_inv);
        cnt_sum = entry_cnt_reg + CNT_W'(1);
        bad_sum = bad_flag_reg || bad_model;
        emit    = in_entry.last_entry || (cnt_sum == CNT_W'(MAX_STACK));

        held_class_next    = held_class_reg;
        held_fraction_next = held_fraction_reg;
        held_rmse_next     = held_rmse_reg;
        held_is_three_next = held_is_three_reg;
        entry_cnt_next     = entry_cnt_reg;
        inv_cnt_next       = inv_cnt_reg;
        bad_flag_next      = bad_flag_reg;
        res_next           = res_reg;
        res_valid_next     = res_valid_reg && !res_ready;

        if (in_take)
        begin
            if (!keep)
            begin
                held_class_next    = cls;
                held_fraction_next = frac;
                held_rmse_next     = in_entry.fit_error;
                held_is_three_next = three;
            end

            if (emit)
            begin
                entry_cnt_next = '0;
                inv_cnt_next   = '0;
                bad_flag_next  = 1'b0;
                res_valid_next = 1'b1;
                res_next.status = bad_sum;
                // no winner when every entry before the last one was invalid
                if (bad_sum || (inv_sum == entry_cnt_reg))
                begin
                    res_next.dominant_class = '0;
                    res_next.dominant_value = cfg.na_value;
                end
                else
                begin
                    res_next.dominant_class = held_class_next;
                    res_next.dominant_value = held_fraction_next;
                end
            end
            else
            begin
                entry_cnt_next = cnt_sum;
                inv_cnt_next   = inv_sum;
                bad_flag_next  = bad_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_cnt_reg <= '0;
            inv_cnt_reg   <= '0;
            bad_flag_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            entry_cnt_reg <= entry_cnt_next;
            inv_cnt_reg   <= inv_cnt_next;
            bad_flag_reg  <= bad_flag_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_class_reg    <= held_class_next;
        held_fraction_reg <= held_fraction_next;
        held_rmse_reg     <= held_rmse_next;
        held_is_three_reg <= held_is_three_next;
        res_reg           <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg < CNT_W'(MAX_STACK))
        else $error("entry count reached stack depth");

    a_inv_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_cnt_reg < entry_cnt_reg) || (inv_cnt_reg == '0))
        else $error("invalid count not below entry count");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && in_entry.last_entry) |=> (entry_cnt_reg == '0) && res_valid_reg)
        else $error("last entry did not close the stack");

    a_status_no_class: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status) |-> (res_reg.dominant_class == '0))
        else $error("error result carries a class");

endmodule

@@ hw/rtl/dominant_model_selector.sv @@
// ----------------------------------------------------------------------------
// dominant_model_selector
// Reduces a pixel's stack of unmixing results to one dominant class and
// fraction.
// ----------------------------------------------------------------------------
// Takes one stack entry per cycle with no gaps while no result beat waits on
// m_tready: a beat is registered at the input, then compared against the
// carried winner and written to the result register. The rate is set by the
// carried-winner update, which is combinational. While a result beat waits on
// m_tready no entry leaves the input register, so s_tready drops once that
// register is full. A stack ends on tlast or on its MAX_STACK-th entry;
// exactly one result beat leaves per stack. The user must write
// configuration through the cfg channel only while the block is idle; the
// block does not enforce it. cfg_ready is always high.
module dominant_model_selector #(
    parameter int MAX_STACK = dms_pkg::MAX_STACK_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dms_pkg::REG_W-1:0]   cfg_index,
    input  logic [dms_pkg::VAL_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // model_count[1:0], frac_a[33:2], frac_b[65:34], fit_error[97:66],
    // class_a[105:98], class_b[113:106], zero pad[119:114]
    input  logic [119:0]                s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // dominant_class[7:0], dominant_value[39:8]
    output logic [39:0]                 m_tdata,
    // status
    output logic                        m_tuser
);

    dms_pkg::dms_cfg_t    cfg;
    dms_pkg::dms_entry_t  entry_reg, entry_next;
    logic                 in_valid_reg, in_valid_next;
    logic                 take;
    dms_pkg::dms_result_t res;

    assign cfg_ready = 1'b1;

    dms_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign s_tready = !in_valid_reg || take;

    always_comb
    begin
        entry_next               = entry_reg;
        in_valid_next            = in_valid_reg && !take;
        if (s_tvalid && s_tready)
        begin
            entry_next.model_count = s_tdata[1:0];
            entry_next.frac_a      = $signed(s_tdata[33:2]);
            entry_next.frac_b      = $signed(s_tdata[65:34]);
            entry_next.fit_error   = $signed(s_tdata[97:66]);
            entry_next.class_a     = s_tdata[105:98];
            entry_next.class_b     = s_tdata[113:106];
            entry_next.last_entry  = s_tlast;
            in_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    dms_stack_core #(
        .MAX_STACK (MAX_STACK)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_entry  (entry_reg),
        .in_take   (take),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.dominant_value, res.dominant_class};
    assign m_tuser = res.status;

endmodule

@@ sim/dominant_model_selector_test.sv @@
// ----------------------------------------------------------------------------
// dominant_model_selector_test
// Stream testbench for the dominant model selector. Pixel stacks go in as
// entry beats with bursts and gaps, results come out under receiver stalls.
// A scoreboard keeps its own winner predictor and checks every result beat.
// ----------------------------------------------------------------------------
module dominant_model_selector_test;

    import dms_pkg::*;

    localparam logic [MC_W-1:0] MC_NONE = 2'd0;
    localparam logic [MC_W-1:0] MC_ONE  = 2'd1;

    localparam int PHASE_ITEMS = 257;

    class winner_checker;
        logic signed [VAL_W-1:0] na_value;
        logic signed [VAL_W-1:0] lower_fraction;
        logic signed [VAL_W-1:0] upper_fraction;
        logic signed [VAL_W-1:0] rmse_limit;
        logic signed [VAL_W-1:0] rmse_margin;

        logic [CLASS_W-1:0]      held_class;
        logic signed [VAL_W-1:0] held_fraction;
        logic signed [VAL_W-1:0] held_rmse;
        bit                      held_three;
        int                      invalid_seen;
        int                      entries_seen;
        bit                      bad_count_seen;

        dms_result_t expected_winners[$];
        int          mismatches;

        function new();
            na_value       = NA_VALUE_RST;
            lower_fraction = LOWER_FRACTION_RST;
            upper_fraction = UPPER_FRACTION_RST;
            rmse_limit     = RMSE_LIMIT_RST;
            rmse_margin    = RMSE_MARGIN_RST;
            mismatches     = 0;
            clear_stack();
        endfunction

        function void clear_stack();
            held_class     = '0;
            held_fraction  = '0;
            held_rmse      = '0;
            held_three     = 1'b0;
            invalid_seen   = 0;
            entries_seen   = 0;
            bad_count_seen = 1'b0;
        endfunction

        function void write_reg(logic [REG_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                REG_NA_VALUE:       na_value       = data;
                REG_LOWER_FRACTION: lower_fraction = data;
                REG_UPPER_FRACTION: upper_fraction = data;
                REG_RMSE_LIMIT:     rmse_limit     = data;
                REG_RMSE_MARGIN:    rmse_margin    = data;
                default: ;
            endcase
        endfunction

        function bit held_rejected();
            return held_fraction == na_value || held_rmse == na_value ||
                   held_fraction < lower_fraction || held_fraction > upper_fraction ||
                   held_rmse > rmse_limit;
        endfunction

        function void take_entry(dms_entry_t e);
            logic signed [VAL_W-1:0] fa;
            logic signed [VAL_W-1:0] fb;
            logic signed [VAL_W-1:0] rmse;
            logic signed [VAL_W-1:0] frac;
            logic [CLASS_W-1:0]      cls;
            bit                      three;
            bit                      keep;
            dms_result_t             r;
            fa    = e.frac_a;
            fb    = e.frac_b;
            rmse  = e.fit_error;
            three = (e.model_count == MC_THREE);
            keep  = 1'b0;
            if (e.model_count != MC_TWO && !three)
                bad_count_seen = 1'b1;
            if (three && fb > fa)
            begin
                frac = fb;
                cls  = e.class_b;
            end
            else
            begin
                frac = fa;
                cls  = e.class_a;
            end
            if (entries_seen != 0)
            begin
                if (held_rejected())
                    invalid_seen++;
                else if (held_three == three)
                    keep = held_fraction > frac;
                else if (!held_three)
                    keep = (longint'(held_rmse) - longint'(rmse)) <= longint'(rmse_margin)
                           || held_fraction > frac;
                else
                    keep = (longint'(rmse) - longint'(held_rmse)) > longint'(rmse_margin)
                           && held_fraction > frac;
            end
            if (!keep)
            begin
                held_class    = cls;
                held_fraction = frac;
                held_rmse     = rmse;
                held_three    = three;
            end
            entries_seen++;
            if (!e.last_entry && entries_seen < MAX_STACK_DEF)
                return;
            if (bad_count_seen)
            begin
                r.status         = 1'b1;
                r.dominant_class = '0;
                r.dominant_value = na_value;
            end
            else if (invalid_seen == entries_seen - 1)
            begin
                r.status         = 1'b0;
                r.dominant_class = '0;
                r.dominant_value = na_value;
            end
            else
            begin
                r.status         = 1'b0;
                r.dominant_class = held_class;
                r.dominant_value = held_fraction;
            end
            expected_winners.push_back(r);
            clear_stack();
        endfunction

        task log_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_winner(logic status, logic [CLASS_W-1:0] cls, logic [VAL_W-1:0] value);
            dms_result_t w;
            if (expected_winners.size() == 0)
            begin
                log_mismatch("result beat with nothing expected");
                return;
            end
            w = expected_winners.pop_front();
            if (status !== w.status)
                log_mismatch($sformatf("status %b, expected %b", status, w.status));
            if (cls !== w.dominant_class)
                log_mismatch($sformatf("class %0d, expected %0d", cls, w.dominant_class));
            if (value !== w.dominant_value)
                log_mismatch($sformatf("value %h, expected %h", value, w.dominant_value));
        endtask

        function int pending();
            return expected_winners.size();
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [REG_W-1:0]    cfg_index = '0;
    logic [VAL_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [119:0]        s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [39:0]         m_tdata;
    logic                m_tuser;

    winner_checker board = new();

    int burst_left  = 0;
    bit steady_feed = 1'b0;
    int phase_items = 0;

    int ready_left  = 0;
    int ready_mode  = 0;
    int ready_shift = 0;
    int rx_tick     = 0;

    dominant_model_selector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // receiver: always ready, coin flip, mostly stalled, or a square wave
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (ready_left == 0)
        begin
            ready_mode  <= $urandom_range(0, 3);
            ready_shift <= $urandom_range(0, 3);
            ready_left  <= $urandom_range(20, 200);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= rx_tick[ready_shift];
        endcase
    end

    always @(posedge clk)
    begin
        dms_entry_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_winner(m_tuser, m_tdata[7:0], m_tdata[39:8]);
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                e.model_count = s_tdata[1:0];
                e.frac_a      = s_tdata[33:2];
                e.frac_b      = s_tdata[65:34];
                e.fit_error   = s_tdata[97:66];
                e.class_a     = s_tdata[105:98];
                e.class_b     = s_tdata[113:106];
                e.last_entry  = s_tlast;
                board.take_entry(e);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] wrap32(longint v);
        return v[VAL_W-1:0];
    endfunction

    task automatic send_entry(dms_entry_t e);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_feed ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, e.class_b, e.class_a, e.fit_error, e.frac_b, e.frac_a,
                     e.model_count};
        s_tlast  <= e.last_entry;
        do
            @(posedge clk);
        while (!s_tready);
        phase_items++;
    endtask

    task automatic send_item(logic [MC_W-1:0] mc, logic [VAL_W-1:0] fa, logic [VAL_W-1:0] fb,
                             logic [VAL_W-1:0] rmse, logic [CLASS_W-1:0] ca,
                             logic [CLASS_W-1:0] cb, bit last);
        dms_entry_t e;
        e.model_count = mc;
        e.frac_a      = fa;
        e.frac_b      = fb;
        e.fit_error   = rmse;
        e.class_a     = ca;
        e.class_b     = cb;
        e.last_entry  = last;
        send_entry(e);
    endtask

    task automatic write_settings(logic [VAL_W-1:0] na, logic [VAL_W-1:0] lo,
                                  logic [VAL_W-1:0] hi, logic [VAL_W-1:0] lim,
                                  logic [VAL_W-1:0] mar);
        logic [VAL_W-1:0] vals[5];
        logic [REG_W-1:0] idx[5];
        vals = '{na, lo, hi, lim, mar};
        idx  = '{REG_NA_VALUE, REG_LOWER_FRACTION, REG_UPPER_FRACTION, REG_RMSE_LIMIT,
                 REG_RMSE_MARGIN};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // drain: input idle, every result back, then a wait for the pipeline to settle
    task automatic drain_block();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_fraction();
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        longint                  span;
        lo   = board.lower_fraction;
        hi   = board.upper_fraction;
        span = longint'(hi) - longint'(lo) + 1;
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return board.na_value;
            2: return lo;
            3: return hi;
            4: return wrap32(longint'(lo) - 1);
            5: return wrap32(longint'(hi) + 1);
            default:
                if (span > 0)
                    return wrap32(longint'(lo) + (longint'($urandom) % span));
                else
                    return $urandom;
        endcase
    endfunction

    // rmse around the previous entry, so margin boundaries get hit
    function automatic logic signed [VAL_W-1:0] pick_rmse(logic signed [VAL_W-1:0] anchor);
        longint m;
        m = board.rmse_margin;
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return board.na_value;
            2: return board.rmse_limit;
            3: return wrap32(longint'(board.rmse_limit) + 1);
            4: return wrap32(longint'(anchor) + m);
            5: return wrap32(longint'(anchor) + m + 1);
            6: return wrap32(longint'(anchor) - m);
            7: return wrap32(longint'(anchor) - m - 1);
            default: return wrap32(longint'(board.rmse_limit) - $urandom_range(0, 4096));
        endcase
    endfunction

    function automatic dms_entry_t shaped_entry(logic signed [VAL_W-1:0] anchor);
        dms_entry_t e;
        int         roll;
        roll = $urandom_range(0, 19);
        if (roll < 9)
            e.model_count = MC_TWO;
        else if (roll < 18)
            e.model_count = MC_THREE;
        else
            e.model_count = $urandom_range(0, 1) ? MC_ONE : MC_NONE;
        e.frac_a     = pick_fraction();
        e.frac_b     = ($urandom_range(0, 5) == 0) ? e.frac_a : pick_fraction();
        e.fit_error  = pick_rmse(anchor);
        e.class_a    = CLASS_W'($urandom_range(0, 255));
        e.class_b    = CLASS_W'($urandom_range(0, 255));
        e.last_entry = 1'b0;
        return e;
    endfunction

    function automatic dms_entry_t noise_entry();
        dms_entry_t e;
        e.model_count = MC_W'($urandom_range(0, 3));
        e.frac_a      = $urandom;
        e.frac_b      = $urandom;
        e.fit_error   = $urandom;
        e.class_a     = CLASS_W'($urandom_range(0, 255));
        e.class_b     = CLASS_W'($urandom_range(0, 255));
        e.last_entry  = 1'($urandom_range(0, 1));
        return e;
    endfunction

    task automatic send_random_stack();
        int                      len;
        bit                      noisy;
        logic signed [VAL_W-1:0] anchor;
        dms_entry_t              e;
        noisy  = ($urandom_range(0, 9) == 0);
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
        anchor = wrap32(longint'(board.rmse_limit) - $urandom_range(0, 2048));
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                e = noise_entry();
            else
            begin
                e = shaped_entry(anchor);
                e.last_entry = (i == len - 1);
            end
            send_entry(e);
            anchor = e.fit_error;
        end
    endtask

    task automatic send_directed();
        // single entry: nothing before it, so no winner
        send_item(MC_TWO, 32'sh8000, 32'sh0, 32'sh100, 8'd7, 8'd9, 1'b1);
        // three-endmember tie goes to class a, kept against a weaker two
        send_item(MC_THREE, 32'sh4000, 32'sh4000, 32'sh200, 8'd5, 8'd6, 1'b0);
        send_item(MC_TWO, 32'sh2000, 32'sh0, 32'sh300, 8'd11, 8'd12, 1'b1);
        // bad model counts
        send_item(MC_NONE, 32'sh1000, 32'sh0, 32'sh10, 8'd3, 8'd4, 1'b0);
        send_item(MC_TWO, 32'sh1000, 32'sh0, 32'sh10, 8'd3, 8'd4, 1'b1);
        send_item(MC_ONE, 32'sh1000, 32'sh2000, 32'sh10, 8'd8, 8'd9, 1'b1);
        // field extremes, held fraction above the upper limit
        send_item(MC_THREE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 8'd255, 8'd0, 1'b0);
        send_item(MC_TWO, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 8'd0, 8'd255, 1'b1);
        // held rmse equal to the no-data value
        send_item(MC_TWO, 32'sh8000, 32'sh0, 32'sh0, 8'd1, 8'd2, 1'b0);
        send_item(MC_TWO, 32'sh100, 32'sh0, 32'sh10, 8'd2, 8'd3, 1'b1);
        // rmse difference exactly at the margin, then a fraction at the upper limit
        send_item(MC_TWO, 32'sh3000, 32'sh0, 32'sh500, 8'd20, 8'd0, 1'b0);
        send_item(MC_THREE, 32'sh1000, 32'sh6000, 32'sh500, 8'd21, 8'd22, 1'b0);
        send_item(MC_TWO, 32'sh10000, 32'sh0, 32'sh10000, 8'd23, 8'd0, 1'b1);
        // full stack without tlast ends on its own
        for (int i = 0; i < MAX_STACK_DEF; i++)
            send_item((i % 2) ? MC_THREE : MC_TWO, i * 32'sh800, i * 32'sh900, i,
                      8'(i + 40), 8'(i + 80), 1'b0);
    endtask

    task automatic apply_setting(int p);
        logic [VAL_W-1:0] lo;
        lo = $urandom;
        case (p)
            1: write_settings($urandom, 32'sd0, 32'sd65536, 32'sd32768, 32'sd2048);
            2: write_settings(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh80000000);
            3: write_settings(32'sh7fffffff, -32'sd65536, 32'sd65536, 32'sh80000000,
                              32'sh7fffffff);
            5: write_settings(32'sd0, lo, wrap32(longint'($signed(lo)) +
                              $urandom_range(0, 1 << 20)), $urandom, $urandom_range(0, 65536));
            7: write_settings(NA_VALUE_RST, LOWER_FRACTION_RST, UPPER_FRACTION_RST,
                              RMSE_LIMIT_RST, RMSE_MARGIN_RST);
            default: write_settings($urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    initial
    begin
        dms_entry_t closing;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int p = 1; p <= 7; p++)
        begin
            drain_block();
            apply_setting(p);
            steady_feed = (p % 3 == 0);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_random_stack();
            // close any stack left open by noise
            closing = shaped_entry(board.rmse_limit);
            closing.last_entry = 1'b1;
            send_entry(closing);
        end
        drain_block();
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
